// ----- rtl/mavg_pkg.sv -----
// ---------------------------------------------------------------------------
// mavg_pkg - shared definitions for the moving-average threshold alarm
// Field widths, reset values and the status bundle of the divider.
// ---------------------------------------------------------------------------
`default_nettype none

package mavg_pkg;

    // Millivolt field width (samples, mean, threshold)
    localparam int MV_W = 12;

    // Quotient width: the mean of 12-bit samples never exceeds 12 bits
    localparam int QUO_W = MV_W;

    // Default averaging window
    localparam int WINDOW_DEFAULT = 8;

    // Alarm threshold after reset
    localparam logic [MV_W-1:0] THRESHOLD_RESET = 12'd1500;

    // Divider status towards the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

// ----- rtl/mavg_if.sv -----
// ---------------------------------------------------------------------------
// mavg_if - stream channels of the moving-average threshold alarm
// Sample channel (in) and result channel (out), valid/ready handshake.
// ---------------------------------------------------------------------------
`default_nettype none

interface mavg_sample_if;
    logic                      valid;
    logic                      ready;
    logic [mavg_pkg::MV_W-1:0] sample_mv;

    modport source (output valid, output sample_mv, input ready);
    modport sink   (input valid, input sample_mv, output ready);
endinterface

interface mavg_result_if;
    logic                      valid;
    logic                      ready;
    logic [mavg_pkg::MV_W-1:0] filtered_mv;
    logic                      alarm;

    modport source (output valid, output filtered_mv, output alarm, input ready);
    modport sink   (input valid, input filtered_mv, input alarm, output ready);
endinterface

`default_nettype wire

// ----- rtl/moving_average_threshold_alarm.sv -----
// ---------------------------------------------------------------------------
// moving_average_threshold_alarm - windowed mean with threshold alarm
// Keeps the last WINDOW millivolt samples, returns their truncated mean and
// an alarm bit for every sample.
// ---------------------------------------------------------------------------
// Each accepted sample word yields one result word: the ring is read at the
// accept edge, then the running sum is updated and the divider started, the
// shared compare-and-subtract divider runs its QUO_W (12) steps, the sequencer
// sees the divider finish, and the output register is loaded once it is empty
// or its result is taken. The divider sets the rate; sample.ready is low from
// accept until the result is loaded, so a new sample is taken only after the
// previous result is loaded. A finished result may wait in the output
// register while the next sample is taken. The ring needs no clearing pass:
// until WINDOW samples have been seen the overwritten entry reads as zero.
// alarm_threshold is written through cfg_wr_en/cfg_wr_data; the user must
// write it only while idle, the block itself does not enforce this.
`default_nettype none

module moving_average_threshold_alarm #(
    parameter int WINDOW = mavg_pkg::WINDOW_DEFAULT
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_wr_en,
    input  wire logic [mavg_pkg::MV_W-1:0] cfg_wr_data,
    mavg_sample_if.sink                    sample,
    mavg_result_if.source                  result
);

    localparam int MV_W   = mavg_pkg::MV_W;
    localparam int QUO_W  = mavg_pkg::QUO_W;
    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int SUM_W  = $clog2(WINDOW * ((1 << MV_W) - 1) + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_UPDATE,
        S_DIVIDE,
        S_FINISH
    } state_t;

    state_t              state_reg;
    logic [MV_W-1:0]     thr_reg;
    logic [MV_W-1:0]     sample_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [SUM_W-1:0]    sum_next;
    logic [SLOT_W-1:0]   slot_reg;
    logic [CNT_W-1:0]    fill_reg;
    logic [CNT_W-1:0]    fill_next;
    logic [MV_W-1:0]     ring_mem [WINDOW];
    logic [MV_W-1:0]     ring_rd_reg;
    logic [MV_W-1:0]     old_mv;
    logic                ring_full;
    logic                accept;
    logic                div_start;
    mavg_pkg::div_stat_t div_stat;
    logic [QUO_W-1:0]    quotient;
    logic                out_valid_reg;
    logic [MV_W-1:0]     out_mv_reg;
    logic                out_alarm_reg;
    logic                out_load;

    assign accept    = sample.valid && sample.ready;
    assign ring_full = (fill_reg == CNT_W'(WINDOW));
    assign div_start = (state_reg == S_UPDATE);
    assign out_load  = (state_reg == S_FINISH) && (!out_valid_reg || result.ready);

    // Drop the overwritten entry; it is zero until the ring has filled
    assign old_mv    = ring_full ? ring_rd_reg : '0;
    assign sum_next  = sum_reg - SUM_W'(old_mv) + SUM_W'(sample_reg);
    assign fill_next = ring_full ? fill_reg : fill_reg + 1'b1;

    // Threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= mavg_pkg::THRESHOLD_RESET;
        end
        else if (cfg_wr_en)
        begin
            thr_reg <= cfg_wr_data;
        end
    end

    // Sample ring: read the slot on accept, write the new word on update
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ring_rd_reg <= ring_mem[slot_reg];
        end
        if (state_reg == S_UPDATE)
        begin
            ring_mem[slot_reg] <= sample_reg;
        end
    end

    // Hold the accepted sample
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg <= sample.sample_mv;
        end
    end

    // Sequencer, window state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sum_reg       <= '0;
            slot_reg      <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_mv_reg    <= '0;
            out_alarm_reg <= 1'b0;
        end
        else
        begin
            if (result.ready && out_valid_reg && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= S_UPDATE;
                    end
                end
                S_UPDATE:
                begin
                    sum_reg  <= sum_next;
                    fill_reg <= fill_next;
                    if (slot_reg == SLOT_W'(WINDOW - 1))
                    begin
                        slot_reg <= '0;
                    end
                    else
                    begin
                        slot_reg <= slot_reg + 1'b1;
                    end
                    state_reg <= S_DIVIDE;
                end
                S_DIVIDE:
                begin
                    if (div_stat.done)
                    begin
                        state_reg <= S_FINISH;
                    end
                end
                S_FINISH:
                begin
                    if (out_load)
                    begin
                        out_valid_reg <= 1'b1;
                        out_mv_reg    <= quotient;
                        out_alarm_reg <= (quotient >= thr_reg);
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Mean of the window: running sum over the fill count
    mavg_div #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_next),
        .divisor  (fill_next),
        .stat     (div_stat),
        .quotient (quotient)
    );

    assign sample.ready       = (state_reg == S_IDLE);
    assign result.valid       = out_valid_reg;
    assign result.filtered_mv = out_mv_reg;
    assign result.alarm       = out_alarm_reg;

    // Checks
    a_ready_not_dividing: assert property (@(posedge clk) disable iff (!rst_n)
        sample.ready |-> !div_stat.busy)
        else $error("sample taken while divider busy");

    a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider restarted while busy");

    a_accept_updates: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_UPDATE))
        else $error("accepted sample did not reach update");

    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(WINDOW))
        else $error("fill count beyond window");

    a_slot_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        32'(slot_reg) < WINDOW)
        else $error("write slot beyond window");

endmodule

`default_nettype wire

// ----- rtl/mavg_div.sv -----
// ---------------------------------------------------------------------------
// mavg_div - iterative unsigned divider
// Restoring long division, one quotient bit per cycle through one shared
// compare-and-subtract. The quotient is known to fit in QUO_W bits.
// ---------------------------------------------------------------------------
`default_nettype none

module mavg_div #(
    parameter int SUM_W = 15,
    parameter int CNT_W = 4
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic [SUM_W-1:0]                dividend,
    input  wire logic [CNT_W-1:0]                divisor,
    output mavg_pkg::div_stat_t                  stat,
    output logic      [mavg_pkg::QUO_W-1:0]      quotient
);

    localparam int QUO_W  = mavg_pkg::QUO_W;
    localparam int SHW    = CNT_W + QUO_W - 1;
    localparam int DW     = (SUM_W > SHW) ? SUM_W : SHW;
    localparam int STEP_W = $clog2(QUO_W);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [DW-1:0]     rem_reg;
    logic [DW-1:0]     dsh_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic              ge;

    // Shared compare: partial remainder against the shifted divisor
    assign ge = (rem_reg >= dsh_reg);

    // Step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(QUO_W - 1);
            end
            else if (busy_reg)
            begin
                if (step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    step_reg <= step_reg - 1'b1;
                end
            end
        end
    end

    // Datapath: subtract where it fits, shift the divisor down one place
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= DW'(dividend);
            dsh_reg <= DW'(divisor) << (QUO_W - 1);
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                rem_reg <= rem_reg - dsh_reg;
            end
            quo_reg <= {quo_reg[QUO_W-2:0], ge};
            dsh_reg <= dsh_reg >> 1;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

`default_nettype wire
